// ===== rtl/tssd_pkg.sv =====
// ----------------------------------------------------------------------------
// tssd_pkg
// Types, glyph table and constants for the temperature display block.
// ----------------------------------------------------------------------------
package tssd_pkg;

  localparam int SEL_W = 3;

  localparam logic [7:0] DOT_MASK        = 8'h7F;
  localparam logic [7:0] BLANK           = 8'hFF;
  localparam logic [7:0] THRESHOLD_RESET = 8'd29;

  localparam logic [7:0] GLYPHS [16] = '{
    8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8,
    8'h80, 8'h90, 8'h88, 8'h83, 8'hC6, 8'hA1, 8'h86, 8'h8E
  };

  // input request
  typedef struct packed {
    logic               operation;
    logic               reading_ok;
    logic signed [11:0] temperature_raw;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [SEL_W-1:0] digit_select;
    logic [7:0]       segment_pattern;
    logic             buzzer_level;
    logic             alarm_active;
  } out_item_t;

  // decoded reading, decoder to top level
  typedef struct packed {
    logic [7:0] tens_glyph;
    logic [7:0] units_glyph;
    logic [7:0] tenths_glyph;
    logic       over_thr;
  } read_dec_t;

  function automatic logic [7:0] glyph(input logic [3:0] val);
    return GLYPHS[val];
  endfunction

endpackage

// ===== rtl/temperature_seven_segment_display.sv =====
// ----------------------------------------------------------------------------
// temperature_seven_segment_display
// An accepted request's result is registered in the output register, or in
// the skid entry while the output is stalled. Throughput: one request per
// cycle while in_stall is low; decode and scan logic sit in a single pass
// before the output register, and the skid entry takes one more request.
// Reset (synchronous, rst_n low): segment buffer all 0xFF, scan index 0,
// alarm clear, buzzer high, threshold 29, output channel empty.
// ----------------------------------------------------------------------------
module temperature_seven_segment_display #(
  parameter int DIGIT_COUNT = 6
) (
  input  logic                clk,
  input  logic                rst_n,
  // request channel
  input  logic                in_valid,
  input  tssd_pkg::in_item_t  in_data,
  output logic                in_stall,
  // result channel
  output logic                out_valid,
  output tssd_pkg::out_item_t out_data,
  input  logic                out_stall,
  // threshold register
  input  logic                cfg_we,
  input  logic [7:0]          cfg_data
);

  localparam int SW = tssd_pkg::SEL_W;

  // positions of the three glyphs of a reading
  localparam logic [SW-1:0] POS_TENS   = SW'(DIGIT_COUNT - 1);
  localparam logic [SW-1:0] POS_UNITS  = SW'(DIGIT_COUNT - 2);
  localparam logic [SW-1:0] POS_TENTHS = SW'(DIGIT_COUNT - 3);
  localparam logic [SW:0]   DC_W       = (SW + 1)'(DIGIT_COUNT);

  // display state
  logic [7:0]    buf_r [DIGIT_COUNT];
  logic [7:0]    buf_nxt [DIGIT_COUNT];
  logic [SW-1:0] scan_r;
  logic [SW-1:0] scan_nxt;
  logic          alarm_r;
  logic          alarm_nxt;
  logic          buzz_r;
  logic          buzz_nxt;
  logic [7:0]    thr_r;

  logic                accept;
  logic [SW-1:0]       sel;
  logic [SW:0]         sel_inc;
  tssd_pkg::read_dec_t dec;
  tssd_pkg::out_item_t res;

  assign accept = in_valid && !in_stall;

  // Reading decode: the failed-reading case is folded in (0.0 is shown).
  tssd_decode u_decode (
    .temperature_raw (in_data.temperature_raw),
    .reading_ok      (in_data.reading_ok),
    .threshold       (thr_r),
    .dec             (dec)
  );

  // Guard against an out-of-range scan index, then the wrap point.
  assign sel     = ({1'b0, scan_r} >= DC_W) ? '0 : scan_r;
  assign sel_inc = {1'b0, sel} + 1'b1;

  always_comb begin
    buf_nxt   = buf_r;
    scan_nxt  = scan_r;
    alarm_nxt = alarm_r;
    buzz_nxt  = buzz_r;
    res.digit_select    = sel;
    res.segment_pattern = tssd_pkg::BLANK;
    if (!in_data.operation) begin
      // scan tick: drive one digit, step the index, run the buzzer
      res.segment_pattern = buf_r[sel];
      scan_nxt = (sel_inc >= DC_W) ? '0 : sel_inc[SW-1:0];
      buzz_nxt = alarm_r ? !buzz_r : 1'b1;
    end else begin
      // reading: refresh the three glyphs; alarm only on a good read
      for (int i = 0; i < DIGIT_COUNT; i++) begin
        if (SW'(i) == POS_TENS)   buf_nxt[i] = dec.tens_glyph;
        if (SW'(i) == POS_UNITS)  buf_nxt[i] = dec.units_glyph;
        if (SW'(i) == POS_TENTHS) buf_nxt[i] = dec.tenths_glyph;
      end
      if (in_data.reading_ok) begin
        alarm_nxt = dec.over_thr;
      end
    end
    res.buzzer_level = buzz_nxt;
    res.alarm_active = alarm_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIGIT_COUNT; i++) begin
        buf_r[i] <= tssd_pkg::BLANK;
      end
      scan_r  <= '0;
      alarm_r <= 1'b0;
      buzz_r  <= 1'b1;
      thr_r   <= tssd_pkg::THRESHOLD_RESET;
    end else begin
      if (accept) begin
        buf_r   <= buf_nxt;
        scan_r  <= scan_nxt;
        alarm_r <= alarm_nxt;
        buzz_r  <= buzz_nxt;
      end
      if (cfg_we) begin
        thr_r <= cfg_data;
      end
    end
  end

  // Result register with skid entry; in_stall comes straight from a flop.
  tssd_out_skid u_out (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (in_valid),
    .s_data  (res),
    .s_stall (in_stall),
    .m_valid (out_valid),
    .m_data  (out_data),
    .m_stall (out_stall)
  );

endmodule

// ===== rtl/tssd_decode.sv =====
// ----------------------------------------------------------------------------
// tssd_decode
// Splits a reading into tens, units and tenths glyphs; threshold compare.
// ----------------------------------------------------------------------------
module tssd_decode (
  input  logic signed [11:0]  temperature_raw,
  input  logic                reading_ok,
  input  logic signed [7:0]   threshold,
  output tssd_pkg::read_dec_t dec
);

  logic signed [7:0] whole_s;
  logic [6:0]        whole_u;
  logic [14:0]       prod;
  logic [3:0]        tens;
  logic [6:0]        units_w;
  logic [7:0]        frac10;
  logic              show;
  logic [3:0]        tens_d;
  logic [3:0]        units_d;
  logic [3:0]        tenths_d;

  // floor(raw/16)
  assign whole_s = temperature_raw[11:4];
  assign whole_u = temperature_raw[10:4];

  // whole/10 via reciprocal, exact for every 7-bit whole value (0 to 127)
  assign prod    = 15'(whole_u) * 15'd205;
  assign tens    = prod[14:11];
  assign units_w = whole_u - {tens, 3'b000} - {2'b00, tens, 1'b0};
  assign frac10  = {1'b0, temperature_raw[3:0], 3'b000} + {3'b000, temperature_raw[3:0], 1'b0};

  // failed or negative reading shows 0.0
  assign show     = reading_ok && !temperature_raw[11];
  assign tens_d   = show ? tens : 4'd0;
  assign units_d  = show ? units_w[3:0] : 4'd0;
  assign tenths_d = show ? frac10[7:4] : 4'd0;

  assign dec.tens_glyph   = tssd_pkg::glyph(tens_d);
  assign dec.units_glyph  = tssd_pkg::glyph(units_d) & tssd_pkg::DOT_MASK;
  assign dec.tenths_glyph = tssd_pkg::glyph(tenths_d);
  assign dec.over_thr     = whole_s > threshold;

endmodule

// ===== rtl/tssd_out_skid.sv =====
// ----------------------------------------------------------------------------
// tssd_out_skid
// Output register plus one skid entry for the result channel.
// ----------------------------------------------------------------------------
module tssd_out_skid (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                s_valid,
  input  tssd_pkg::out_item_t s_data,
  output logic                s_stall,
  output logic                m_valid,
  output tssd_pkg::out_item_t m_data,
  input  logic                m_stall
);

  logic                out_valid_r;
  logic                skid_valid_r;
  tssd_pkg::out_item_t out_r;
  tssd_pkg::out_item_t skid_r;
  logic                push;
  logic                pop;

  assign s_stall = skid_valid_r;
  assign push    = s_valid && !skid_valid_r;
  assign pop     = out_valid_r && !m_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        out_r        <= skid_r;
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        out_r       <= s_data;
        out_valid_r <= 1'b1;
      end else begin
        skid_r       <= s_data;
        skid_valid_r <= 1'b1;
      end
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  assign m_valid = out_valid_r;
  assign m_data  = out_r;

endmodule
